// File: src/arir_pkg.sv
// Shared constants, codes and types for the ARP / ICMP echo reply builder.
package arir_pkg;

   // Default frame buffer size in bytes
   localparam int MAX_FRAME_BYTES = 512;

   // Ethernet + IPv4 + ICMP header length (also the ARP frame length), and IPv4 + ICMP header length
   localparam int HDR_BYTES         = 42;
   localparam int IP_ICMP_HDR_BYTES = 28;

   // Request selector codes
   localparam logic [1:0] REQ_ARP      = 2'd0;
   localparam logic [1:0] REQ_ECHO_HDR = 2'd1;
   localparam logic [1:0] REQ_CHUNK    = 2'd2;

   // Register index of own_mac (one 64-bit register slot)
   localparam logic CSR_IDX_OWN_MAC = 1'b0;

   // Protocol field values
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
   localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
   localparam logic [7:0]  ARP_HLEN       = 8'd6;
   localparam logic [7:0]  ARP_PLEN       = 8'd4;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TOS         = 8'h00;
   localparam logic [15:0] IP_FLAGS_FRAG  = 16'h0000;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
   localparam logic [7:0]  ICMP_CODE_ZERO  = 8'd0;

   typedef logic [47:0] mac_type;
   typedef logic [31:0] ip_type;
   typedef logic [63:0] word_type;

endpackage

// File: src/arir_if.sv
// Request and reply stream interfaces of the ARP / ICMP echo reply builder.
interface arir_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   arir_pkg::mac_type   frame_src_mac;
   arir_pkg::mac_type   sender_mac;
   arir_pkg::ip_type    sender_ip;
   arir_pkg::ip_type    target_ip;
   logic [15:0]         ip_ident;
   logic [15:0]         echo_ident;
   logic [15:0]         echo_seq;
   logic signed [16:0]  data_len;
   arir_pkg::word_type  chunk_data;
   logic                chunk_last;

   modport source (
      output valid, req_type, frame_src_mac, sender_mac, sender_ip, target_ip,
             ip_ident, echo_ident, echo_seq, data_len, chunk_data, chunk_last,
      input  ready
   );
   modport sink (
      input  valid, req_type, frame_src_mac, sender_mac, sender_ip, target_ip,
             ip_ident, echo_ident, echo_seq, data_len, chunk_data, chunk_last,
      output ready
   );
endinterface

interface arir_rsp_if;
   logic                valid;
   logic                ready;
   arir_pkg::word_type  frame_word;
   logic [3:0]          valid_bytes;
   logic                frame_last;

   modport source (output valid, frame_word, valid_bytes, frame_last, input ready);
   modport sink   (input  valid, frame_word, valid_bytes, frame_last, output ready);
endinterface

// File: src/arp_icmp_reply_builder.sv
// Top level: ARP reply and ICMP echo reply frame builder with payload store.
// ARP request: checksum/length prep in ST_SUM and ST_FOLD, then 6 words at one per
// cycle while the output is not stalled. Echo: one payload chunk beat per cycle; after
// the last chunk (or a zero length header) the same prep, then ceil((42+len)/8) words,
// one per cycle from the store while the output is not stalled. The first word is
// registered in ST_EMIT; input is held off until the last word is in the output register.
// Reset (synchronous, active high) clears control state and own_mac; no store sweep.
module arp_icmp_reply_builder #(
   parameter int MAX_FRAME_BYTES = arir_pkg::MAX_FRAME_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   arir_req_if.sink          req_bus,
   arir_rsp_if.source        rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int MAX_PAYLOAD = MAX_FRAME_BYTES - arir_pkg::HDR_BYTES;
   localparam int STORE_DEPTH = (MAX_PAYLOAD + 7) / 8;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int FB_W        = $clog2(MAX_FRAME_BYTES + 1);
   localparam int MAX_WORDS   = (MAX_FRAME_BYTES + 7) / 8;
   localparam int WORD_W      = $clog2(MAX_WORDS);
   // first word that carries payload bytes
   localparam int PAY_WORD    = arir_pkg::HDR_BYTES / 8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_FOLD = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // ones' complement fold of a 32-bit sum down to 16 bits
   function automatic logic [15:0] fold16(input logic [31:0] s);
      logic [16:0] t;
      logic [16:0] u;
      t = {1'b0, s[15:0]} + {1'b0, s[31:16]};
      u = {1'b0, t[15:0]} + {16'b0, t[16]};
      return u[15:0];
   endfunction

   // store entry whose high bytes feed frame word w
   function automatic logic [WORD_W-1:0] entry_of(input logic [WORD_W-1:0] w);
      return (w >= WORD_W'(PAY_WORD)) ? w - WORD_W'(PAY_WORD) : '0;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [1:0]          state_ff, state_in;
   logic [47:0]         own_mac_ff, own_mac_in;
   logic                echo_kind_ff, echo_kind_in;
   logic [47:0]         arp_dst_mac_ff, arp_dst_mac_in;
   logic [47:0]         arp_tha_ff, arp_tha_in;
   logic [31:0]         arp_spa_ff, arp_spa_in;
   logic [31:0]         arp_tpa_ff, arp_tpa_in;
   logic [47:0]         held_mac_ff, held_mac_in;
   logic [31:0]         held_src_ip_ff, held_src_ip_in;
   logic [31:0]         held_dst_ip_ff, held_dst_ip_in;
   logic [15:0]         ip_ident_ff, ip_ident_in;
   logic [15:0]         echo_ident_ff, echo_ident_in;
   logic [15:0]         echo_seq_ff, echo_seq_in;
   logic [LEN_W-1:0]    clamped_ff, clamped_in;
   logic [LEN_W-1:0]    loaded_ff, loaded_in;
   logic [31:0]         sum_ff, sum_in;
   logic                open_ff, open_in;
   logic [19:0]         ip_sum_ff, ip_sum_in;
   logic [15:0]         icmp_part_ff, icmp_part_in;
   logic [15:0]         ip_csum_ff, ip_csum_in;
   logic [15:0]         icmp_csum_ff, icmp_csum_in;
   logic [WORD_W-1:0]   word_cnt_ff, word_cnt_in;
   logic [WORD_W-1:0]   last_word_ff, last_word_in;
   logic [3:0]          last_valid_ff, last_valid_in;
   logic [63:0]         rd_data_ff;
   logic [63:0]         prev_ff, prev_in;
   logic                prev_ok_ff, prev_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_word_ff, rsp_word_in;
   logic [3:0]          rsp_bytes_ff, rsp_bytes_in;
   logic                rsp_last_ff, rsp_last_in;

   // payload store
   logic [63:0]         store_mem [STORE_DEPTH];
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [63:0]         mem_wdata;
   logic [ADDR_W-1:0]   rd_addr;

   // ---------------------------------------------------------------- helpers
   logic                req_fire;
   logic                csr_write;
   logic [LEN_W-1:0]    len_clamped;
   logic [LEN_W-1:0]    rem_bytes;
   logic                rem_full;
   logic [63:0]         chunk_masked;
   logic [15:0]         total_ip;
   logic [15:0]         ident_plus;
   logic [335:0]        hdr_vec;
   logic [383:0]        frame_vec;
   logic [63:0]         base_word;
   logic [LEN_W:0]      lw_sum;
   logic [WORD_W-1:0]   loaded_words;
   logic                cur_ok;
   logic [63:0]         cur_m;
   logic [63:0]         prev_m;
   logic                out_free;
   logic [FB_W-1:0]     nbytes;
   logic [FB_W-1:0]     nbytes_m1;
   logic [WORD_W-1:0]   addr_next;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == arir_pkg::CSR_IDX_OWN_MAC) ? {16'b0, own_mac_ff} : '0;

   // header length clamp
   always_comb begin
      if (req_bus.data_len[16])
         len_clamped = '0;
      else if (req_bus.data_len[15:0] > 16'(MAX_PAYLOAD))
         len_clamped = LEN_W'(MAX_PAYLOAD);
      else
         len_clamped = LEN_W'(req_bus.data_len[15:0]);
   end

   // chunk trimming against the bytes still expected
   always_comb begin
      rem_bytes = (loaded_ff < clamped_ff) ? clamped_ff - loaded_ff : '0;
      rem_full  = rem_bytes >= LEN_W'(8);
      for (int b = 0; b < 8; b++) begin
         if (rem_full || (LEN_W'(b) < rem_bytes))
            chunk_masked[63 - 8 * b -: 8] = req_bus.chunk_data[63 - 8 * b -: 8];
         else
            chunk_masked[63 - 8 * b -: 8] = 8'h00;
      end
   end

   // reply header fields
   assign total_ip   = 16'(arir_pkg::IP_ICMP_HDR_BYTES) + 16'(clamped_ff);
   assign ident_plus = ip_ident_ff + 16'd1;

   always_comb begin
      if (echo_kind_ff)
         hdr_vec = {held_mac_ff, own_mac_ff, arir_pkg::ETHERTYPE_IPV4,
                    arir_pkg::IP_VER_IHL, arir_pkg::IP_TOS, total_ip, ident_plus,
                    arir_pkg::IP_FLAGS_FRAG, arir_pkg::IP_TTL, arir_pkg::IP_PROTO_ICMP,
                    ip_csum_ff, held_src_ip_ff, held_dst_ip_ff,
                    arir_pkg::ICMP_ECHO_REPLY, arir_pkg::ICMP_CODE_ZERO, icmp_csum_ff,
                    echo_ident_ff, echo_seq_ff};
      else
         hdr_vec = {arp_dst_mac_ff, own_mac_ff, arir_pkg::ETHERTYPE_ARP,
                    arir_pkg::ARP_HTYPE_ETH, arir_pkg::ETHERTYPE_IPV4,
                    arir_pkg::ARP_HLEN, arir_pkg::ARP_PLEN, arir_pkg::ARP_OP_REPLY,
                    own_mac_ff, arp_spa_ff, arp_tha_ff, arp_tpa_ff};
   end
   assign frame_vec = {hdr_vec, 48'b0};

   // header part of the current word
   always_comb begin
      case (word_cnt_ff)
         WORD_W'(0): base_word = frame_vec[383:320];
         WORD_W'(1): base_word = frame_vec[319:256];
         WORD_W'(2): base_word = frame_vec[255:192];
         WORD_W'(3): base_word = frame_vec[191:128];
         WORD_W'(4): base_word = frame_vec[127:64];
         WORD_W'(5): base_word = frame_vec[63:0];
         default:    base_word = '0;
      endcase
   end

   // payload part: low two bytes of the previous entry, high six of the current
   assign lw_sum       = {1'b0, loaded_ff} + (LEN_W + 1)'(7);
   assign loaded_words = WORD_W'(lw_sum >> 3);
   assign cur_ok       = echo_kind_ff && (word_cnt_ff >= WORD_W'(PAY_WORD))
                         && (entry_of(word_cnt_ff) < loaded_words);
   assign cur_m        = cur_ok ? rd_data_ff : '0;
   assign prev_m       = prev_ok_ff ? prev_ff : '0;

   // frame length of the pending reply
   assign nbytes    = echo_kind_ff ? FB_W'(arir_pkg::HDR_BYTES) + FB_W'(clamped_ff)
                                   : FB_W'(arir_pkg::HDR_BYTES);
   assign nbytes_m1 = nbytes - FB_W'(1);

   // main next-state logic
   always_comb begin
      state_in       = state_ff;
      own_mac_in     = own_mac_ff;
      echo_kind_in   = echo_kind_ff;
      arp_dst_mac_in = arp_dst_mac_ff;
      arp_tha_in     = arp_tha_ff;
      arp_spa_in     = arp_spa_ff;
      arp_tpa_in     = arp_tpa_ff;
      held_mac_in    = held_mac_ff;
      held_src_ip_in = held_src_ip_ff;
      held_dst_ip_in = held_dst_ip_ff;
      ip_ident_in    = ip_ident_ff;
      echo_ident_in  = echo_ident_ff;
      echo_seq_in    = echo_seq_ff;
      clamped_in     = clamped_ff;
      loaded_in      = loaded_ff;
      sum_in         = sum_ff;
      open_in        = open_ff;
      ip_sum_in      = ip_sum_ff;
      icmp_part_in   = icmp_part_ff;
      ip_csum_in     = ip_csum_ff;
      icmp_csum_in   = icmp_csum_ff;
      word_cnt_in    = word_cnt_ff;
      last_word_in   = last_word_ff;
      last_valid_in  = last_valid_ff;
      prev_in        = prev_ff;
      prev_ok_in     = prev_ok_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = ADDR_W'(loaded_ff >> 3);
      mem_wdata      = chunk_masked;

      if (csr_write && (csr_paddr[3] == arir_pkg::CSR_IDX_OWN_MAC))
         own_mac_in = csr_pwdata[47:0];

      // reply beat taken downstream
      if (rsp_valid_ff && rsp_bus.ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.req_type)
                  arir_pkg::REQ_ARP: begin
                     echo_kind_in   = 1'b0;
                     arp_dst_mac_in = req_bus.frame_src_mac;
                     arp_tha_in     = req_bus.sender_mac;
                     arp_spa_in     = req_bus.target_ip;
                     arp_tpa_in     = req_bus.sender_ip;
                     state_in       = ST_SUM;
                  end
                  arir_pkg::REQ_ECHO_HDR: begin
                     held_mac_in    = req_bus.frame_src_mac;
                     held_src_ip_in = req_bus.target_ip;
                     held_dst_ip_in = req_bus.sender_ip;
                     ip_ident_in    = req_bus.ip_ident;
                     echo_ident_in  = req_bus.echo_ident;
                     echo_seq_in    = req_bus.echo_seq;
                     clamped_in     = len_clamped;
                     loaded_in      = '0;
                     sum_in         = '0;
                     open_in        = 1'b1;
                     if (len_clamped == '0) begin
                        open_in      = 1'b0;
                        echo_kind_in = 1'b1;
                        state_in     = ST_SUM;
                     end
                  end
                  arir_pkg::REQ_CHUNK: begin
                     if (open_ff) begin
                        if (rem_bytes != '0) begin
                           mem_we    = 1'b1;
                           sum_in    = sum_ff + 32'(chunk_masked[63:48])
                                       + 32'(chunk_masked[47:32])
                                       + 32'(chunk_masked[31:16])
                                       + 32'(chunk_masked[15:0]);
                           loaded_in = loaded_ff + (rem_full ? LEN_W'(8) : rem_bytes);
                        end
                        if (req_bus.chunk_last) begin
                           open_in      = 1'b0;
                           echo_kind_in = 1'b1;
                           state_in     = ST_SUM;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // header sum and running-sum fold, frame length
         ST_SUM: begin
            ip_sum_in     = 20'({arir_pkg::IP_VER_IHL, arir_pkg::IP_TOS})
                            + 20'(total_ip) + 20'(ident_plus)
                            + 20'({arir_pkg::IP_TTL, arir_pkg::IP_PROTO_ICMP})
                            + 20'(held_src_ip_ff[31:16]) + 20'(held_src_ip_ff[15:0])
                            + 20'(held_dst_ip_ff[31:16]) + 20'(held_dst_ip_ff[15:0]);
            icmp_part_in  = fold16(sum_ff);
            last_word_in  = WORD_W'(nbytes_m1 >> 3);
            last_valid_in = 4'(nbytes_m1[2:0]) + 4'd1;
            word_cnt_in   = '0;
            prev_ok_in    = 1'b0;
            state_in      = ST_FOLD;
         end

         // final checksums
         ST_FOLD: begin
            ip_csum_in   = ~fold16(32'(ip_sum_ff));
            icmp_csum_in = ~fold16(32'(icmp_part_ff) + 32'(echo_ident_ff) + 32'(echo_seq_ff));
            state_in     = ST_EMIT;
         end

         // one frame word per free output slot
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = base_word | {prev_m[15:0], cur_m[63:16]};
               rsp_last_in  = word_cnt_ff == last_word_ff;
               rsp_bytes_in = (word_cnt_ff == last_word_ff) ? last_valid_ff : 4'd8;
               prev_in      = rd_data_ff;
               prev_ok_in   = cur_ok;
               if (word_cnt_ff == last_word_ff) begin
                  word_cnt_in = '0;
                  state_in    = ST_IDLE;
               end else begin
                  word_cnt_in = word_cnt_ff + WORD_W'(1);
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // read address follows the word that is current next cycle
   assign addr_next = entry_of(word_cnt_in);
   assign rd_addr   = (addr_next < WORD_W'(STORE_DEPTH)) ? addr_next[ADDR_W-1:0] : '0;

   // payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we)
         store_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= store_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_mac_ff   <= '0;
         clamped_ff   <= '0;
         loaded_ff    <= '0;
         sum_ff       <= '0;
         open_ff      <= 1'b0;
         word_cnt_ff  <= '0;
         prev_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_mac_ff   <= own_mac_in;
         clamped_ff   <= clamped_in;
         loaded_ff    <= loaded_in;
         sum_ff       <= sum_in;
         open_ff      <= open_in;
         word_cnt_ff  <= word_cnt_in;
         prev_ok_ff   <= prev_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      echo_kind_ff   <= echo_kind_in;
      arp_dst_mac_ff <= arp_dst_mac_in;
      arp_tha_ff     <= arp_tha_in;
      arp_spa_ff     <= arp_spa_in;
      arp_tpa_ff     <= arp_tpa_in;
      held_mac_ff    <= held_mac_in;
      held_src_ip_ff <= held_src_ip_in;
      held_dst_ip_ff <= held_dst_ip_in;
      ip_ident_ff    <= ip_ident_in;
      echo_ident_ff  <= echo_ident_in;
      echo_seq_ff    <= echo_seq_in;
      ip_sum_ff      <= ip_sum_in;
      icmp_part_ff   <= icmp_part_in;
      ip_csum_ff     <= ip_csum_in;
      icmp_csum_ff   <= icmp_csum_in;
      last_word_ff   <= last_word_in;
      last_valid_ff  <= last_valid_in;
      prev_ff        <= prev_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_bytes_ff   <= rsp_bytes_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // stream ports
   assign req_bus.ready       = state_ff == ST_IDLE;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.frame_word  = rsp_word_ff;
   assign rsp_bus.valid_bytes = rsp_bytes_ff;
   assign rsp_bus.frame_last  = rsp_last_ff;

endmodule

// File: tb/tb_arp_icmp_reply_builder.sv
// Testbench for the ARP / ICMP echo reply builder: predicted reply frames vs. output stream.
module tb_arp_icmp_reply_builder;

   localparam int          MAX_FRAME_BYTES  = arir_pkg::MAX_FRAME_BYTES;
   localparam int          HDR_BYTES        = arir_pkg::HDR_BYTES;
   localparam int          MAX_PAYLOAD      = MAX_FRAME_BYTES - HDR_BYTES;
   localparam int          PAYLOAD_WORDS    = (MAX_PAYLOAD + 7) / 8;
   localparam logic [1:0]  REQ_UNUSED       = 2'd3;
   localparam logic [3:0]  CSR_ADDR_OWN_MAC = 4'(8 * arir_pkg::CSR_IDX_OWN_MAC);
   localparam int          DRAIN_CYCLES     = 16;
   localparam int          RX_HOLD_CYCLES   = 400;

   // One request as presented on the input channel
   typedef struct packed {
      logic [1:0]         kind;
      logic [47:0]        dst_mac;
      logic [47:0]        snd_mac;
      logic [31:0]        snd_ip;
      logic [31:0]        tgt_ip;
      logic [15:0]        ip_id;
      logic [15:0]        e_id;
      logic [15:0]        e_seq;
      logic signed [16:0] plen;
      logic [63:0]        data;
      logic               last;
   } req_item_type;

   // One beat of a reply frame
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } reply_beat_type;

   // Reply frame predictor and expected-beat store
   class reply_scoreboard;
      logic [47:0]  station_mac;
      logic [63:0]  payload_words [PAYLOAD_WORDS];
      logic [47:0]  echo_mac;
      logic [31:0]  echo_src_ip;
      logic [31:0]  echo_dst_ip;
      logic [15:0]  echo_ip_id;
      logic [15:0]  echo_id;
      logic [15:0]  echo_seq;
      int unsigned  echo_len;
      int unsigned  echo_loaded;
      logic [31:0]  echo_sum;
      bit           echo_open;
      logic [7:0]   frame [MAX_FRAME_BYTES];
      reply_beat_type expected_q [$];
      int           errors;

      function new();
         station_mac = '0;
         echo_mac    = '0;
         echo_src_ip = '0;
         echo_dst_ip = '0;
         echo_ip_id  = '0;
         echo_id     = '0;
         echo_seq    = '0;
         echo_len    = 0;
         echo_loaded = 0;
         echo_sum    = '0;
         echo_open   = 0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // big-endian field write into the frame image
      function void put(int pos, logic [63:0] val, int n);
         int i;
         for (i = 0; i < n; i++) begin
            if (pos + i < MAX_FRAME_BYTES) frame[pos + i] = val[8 * (n - 1 - i) +: 8];
         end
      endfunction

      function logic [15:0] fold_csum(logic [31:0] s);
         while (s[31:16] != 16'h0) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
         return ~s[15:0];
      endfunction

      function void clear_frame();
         int i;
         for (i = 0; i < MAX_FRAME_BYTES; i++) frame[i] = 8'h00;
      endfunction

      // slice the frame image into 8-byte beats
      function void push_frame(int n);
         int             words;
         int             w;
         int             b;
         int             idx;
         int             nb;
         reply_beat_type beat;
         words = (n + 7) / 8;
         for (w = 0; w < words; w++) begin
            beat.word = '0;
            for (b = 0; b < 8; b++) begin
               idx = w * 8 + b;
               beat.word = {beat.word[55:0], (idx < n) ? frame[idx] : 8'h00};
            end
            nb = n - w * 8;
            if (nb > 8) nb = 8;
            beat.nbytes = 4'(nb);
            beat.last   = (w == words - 1);
            expected_q.push_back(beat);
         end
      endfunction

      function void build_arp(req_item_type it);
         clear_frame();
         put(0, it.dst_mac, 6);
         put(6, station_mac, 6);
         put(12, arir_pkg::ETHERTYPE_ARP, 2);
         put(14, arir_pkg::ARP_HTYPE_ETH, 2);
         put(16, arir_pkg::ETHERTYPE_IPV4, 2);
         put(18, arir_pkg::ARP_HLEN, 1);
         put(19, arir_pkg::ARP_PLEN, 1);
         put(20, arir_pkg::ARP_OP_REPLY, 2);
         put(22, station_mac, 6);
         put(28, it.tgt_ip, 4);
         put(32, it.snd_mac, 6);
         put(38, it.snd_ip, 4);
         push_frame(HDR_BYTES);
      endfunction

      function void build_echo();
         logic [15:0] total;
         logic [15:0] ident;
         logic [31:0] s;
         int          i;
         total = 16'(arir_pkg::IP_ICMP_HDR_BYTES + echo_len);
         ident = echo_ip_id + 16'd1;
         clear_frame();
         put(0, echo_mac, 6);
         put(6, station_mac, 6);
         put(12, arir_pkg::ETHERTYPE_IPV4, 2);
         put(14, {arir_pkg::IP_VER_IHL, arir_pkg::IP_TOS}, 2);
         put(16, total, 2);
         put(18, ident, 2);
         put(20, arir_pkg::IP_FLAGS_FRAG, 2);
         put(22, {arir_pkg::IP_TTL, arir_pkg::IP_PROTO_ICMP}, 2);
         s = {16'h0, arir_pkg::IP_VER_IHL, arir_pkg::IP_TOS} + {16'h0, total}
             + {16'h0, ident} + {16'h0, arir_pkg::IP_FLAGS_FRAG}
             + {16'h0, arir_pkg::IP_TTL, arir_pkg::IP_PROTO_ICMP}
             + {16'h0, echo_src_ip[31:16]} + {16'h0, echo_src_ip[15:0]}
             + {16'h0, echo_dst_ip[31:16]} + {16'h0, echo_dst_ip[15:0]};
         put(24, fold_csum(s), 2);
         put(26, echo_src_ip, 4);
         put(30, echo_dst_ip, 4);
         put(34, {arir_pkg::ICMP_ECHO_REPLY, arir_pkg::ICMP_CODE_ZERO}, 2);
         put(38, echo_id, 2);
         put(40, echo_seq, 2);
         // only loaded bytes are copied; the rest stays zero
         for (i = 0; i < echo_len && i < echo_loaded; i++) begin
            frame[HDR_BYTES + i] = payload_words[i / 8][8 * (7 - i % 8) +: 8];
         end
         s = {16'h0, fold_csum(echo_sum) ^ 16'hFFFF} + {16'h0, echo_id} + {16'h0, echo_seq};
         put(36, fold_csum(s), 2);
         echo_open = 0;
         push_frame(HDR_BYTES + echo_len);
      endfunction

      // accepted request; returns 0 when the block ignores it
      function bit note(req_item_type it);
         int unsigned n;
         logic [63:0] d;
         case (it.kind)
            arir_pkg::REQ_ARP: begin
               build_arp(it);
               return 1;
            end
            arir_pkg::REQ_ECHO_HDR: begin
               echo_mac    = it.dst_mac;
               echo_src_ip = it.tgt_ip;
               echo_dst_ip = it.snd_ip;
               echo_ip_id  = it.ip_id;
               echo_id     = it.e_id;
               echo_seq    = it.e_seq;
               if (it.plen[16]) echo_len = 0;
               else if (int'(it.plen) > MAX_PAYLOAD) echo_len = MAX_PAYLOAD;
               else echo_len = int'(it.plen);
               echo_loaded = 0;
               echo_sum    = '0;
               echo_open   = 1;
               if (echo_len == 0) build_echo();
               return 1;
            end
            arir_pkg::REQ_CHUNK: begin
               if (!echo_open) return 0;
               n = (echo_loaded < echo_len) ? echo_len - echo_loaded : 0;
               if (n > 8) n = 8;
               if (n > 0) begin
                  d = it.data;
                  if (n < 8) d &= ~64'h0 << (64 - 8 * n);
                  payload_words[echo_loaded / 8] = d;
                  echo_sum = echo_sum + {16'h0, d[63:48]} + {16'h0, d[47:32]}
                             + {16'h0, d[31:16]} + {16'h0, d[15:0]};
                  echo_loaded += n;
               end
               if (it.last) build_echo();
               return 1;
            end
            default: return 0;
         endcase
      endfunction

      task report(string msg);
         if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task check(reply_beat_type got);
         reply_beat_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("reply beat %h with nothing expected", got.word));
            return;
         end
         want = expected_q.pop_front();
         if (got.word !== want.word)
            report($sformatf("frame_word got %h want %h", got.word, want.word));
         if (got.nbytes !== want.nbytes)
            report($sformatf("valid_bytes got %0d want %0d", got.nbytes, want.nbytes));
         if (got.last !== want.last)
            report($sformatf("frame_last got %b want %b", got.last, want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   arir_req_if req_bus ();
   arir_rsp_if rsp_bus ();

   arp_icmp_reply_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   reply_scoreboard sb = new();
   int  tx_idle_pct;
   int  rx_idle_pct;
   int  used_count;
   bit  rx_blocked;
   event hold_rx;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall limit
   initial begin
      #(8 * 1_500_000);
      $display("FAIL arp_icmp_reply_builder");
      $finish;
   end

   // long receiver hold-off, counted here
   initial begin
      int k;
      rx_blocked <= 1'b0;
      forever begin
         @(hold_rx);
         rx_blocked <= 1'b1;
         for (k = 0; k < RX_HOLD_CYCLES; k++) @(posedge clock);
         rx_blocked <= 1'b0;
      end
   end

   // reply sink: check each accepted beat, then pick next ready
   initial begin
      reply_beat_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.word   = rsp_bus.frame_word;
            got.nbytes = rsp_bus.valid_bytes;
            got.last   = rsp_bus.frame_last;
            sb.check(got);
         end
         rsp_bus.ready <= !reset && !rx_blocked && (int'($urandom_range(99)) >= rx_idle_pct);
      end
   end

   function automatic req_item_type make_req(logic [1:0] kind, logic signed [16:0] plen,
                                             logic last);
      req_item_type it;
      it.kind    = kind;
      it.dst_mac = 48'({$urandom, $urandom});
      it.snd_mac = 48'({$urandom, $urandom});
      it.snd_ip  = $urandom;
      it.tgt_ip  = $urandom;
      it.ip_id   = 16'($urandom);
      it.e_id    = 16'($urandom);
      it.e_seq   = 16'($urandom);
      it.plen    = plen;
      it.data    = {$urandom, $urandom};
      it.last    = last;
      return it;
   endfunction

   function automatic logic signed [16:0] rand_len();
      int r;
      r = int'($urandom_range(99));
      if (r < 50) return 17'($urandom_range(1, 48));
      if (r < 75) return 17'($urandom_range(49, 160));
      if (r < 85) return 17'($urandom_range(161, MAX_PAYLOAD));
      if (r < 90) return 17'sd0;
      if (r < 95) return 17'(-int'($urandom_range(1, 32768)));
      return 17'($urandom_range(MAX_PAYLOAD + 1, 65535));
   endfunction

   // present one request; valid stays up unless an idle gap follows
   task automatic send(req_item_type it);
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= it.kind;
      req_bus.frame_src_mac <= it.dst_mac;
      req_bus.sender_mac    <= it.snd_mac;
      req_bus.sender_ip     <= it.snd_ip;
      req_bus.target_ip     <= it.tgt_ip;
      req_bus.ip_ident      <= it.ip_id;
      req_bus.echo_ident    <= it.e_id;
      req_bus.echo_seq      <= it.e_seq;
      req_bus.data_len      <= it.plen;
      req_bus.chunk_data    <= it.data;
      req_bus.chunk_last    <= it.last;
      do @(posedge clock); while (!req_bus.ready);
      if (sb.note(it)) used_count++;
      if (int'($urandom_range(99)) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every expected beat, plus optional slack
   task automatic settle(int slack);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (slack) @(posedge clock);
   endtask

   task automatic write_mac(logic [47:0] mac);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_OWN_MAC;
      csr_pwdata  <= {16'($urandom), mac};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.station_mac = mac;
   endtask

   // style: 0 well formed, 1 early last, 2 extra chunks, 3 left open
   task automatic run_echo(logic signed [16:0] plen, int style);
      int  clen;
      int  n;
      int  cnt;
      int  i;
      bit  close;
      send(make_req(arir_pkg::REQ_ECHO_HDR, plen, 1'b0));
      if (plen < 0) clen = 0;
      else if (int'(plen) > MAX_PAYLOAD) clen = MAX_PAYLOAD;
      else clen = int'(plen);
      if (clen == 0) return;
      n = (clen + 7) / 8;
      close = 1;
      case (style)
         1:       cnt = int'($urandom_range(1, n));
         2:       cnt = n + int'($urandom_range(1, 2));
         3: begin
            cnt   = int'($urandom_range(0, n - 1));
            close = 0;
         end
         default: cnt = n;
      endcase
      for (i = 0; i < cnt; i++) begin
         if (int'($urandom_range(99)) < 4) send(make_req(arir_pkg::REQ_ARP, 17'sd0, 1'b0));
         send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, close && (i == cnt - 1)));
      end
   endtask

   task automatic random_phase(int target);
      int goal;
      int r;
      int style;
      goal = used_count + target;
      while (used_count < goal) begin
         r = int'($urandom_range(99));
         if (r < 18) begin
            send(make_req(arir_pkg::REQ_ARP, 17'($urandom), 1'($urandom)));
         end else if (r < 24) begin
            if (r[0]) send(make_req(REQ_UNUSED, 17'($urandom), 1'($urandom)));
            else send(make_req(arir_pkg::REQ_CHUNK, 17'($urandom), 1'($urandom)));
         end else begin
            r = int'($urandom_range(99));
            style = (r < 75) ? 0 : (r < 85) ? 1 : (r < 93) ? 2 : 3;
            run_echo(rand_len(), style);
         end
         if (int'($urandom_range(99)) < 2) settle(0);
      end
   endtask

   task automatic directed();
      req_item_type it;
      // ARP with all-zero and all-one fields
      it = '0;
      it.kind = arir_pkg::REQ_ARP;
      send(it);
      it = '1;
      it.kind = arir_pkg::REQ_ARP;
      send(it);
      // zero length echo replies at once
      it = '0;
      it.kind = arir_pkg::REQ_ECHO_HDR;
      send(it);
      // negative length, identification wraps
      it = '1;
      it.kind = arir_pkg::REQ_ECHO_HDR;
      it.plen = -17'sd32768;
      send(it);
      // oversized length cut short by an early last chunk
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd65535, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b1));
      // short length: tail bytes dropped, surplus chunk ignored
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd5, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b0));
      it = '1;
      it.kind = arir_pkg::REQ_CHUNK;
      send(it);
      // new header drops the open echo
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd20, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b0));
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd8, 1'b0));
      send(it);
      // chunk with no echo open, unused selector
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b1));
      send(make_req(REQ_UNUSED, 17'sd3, 1'b1));
      // ARP in the middle of an echo
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd16, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b0));
      send(make_req(arir_pkg::REQ_ARP, 17'sd0, 1'b0));
      send(make_req(arir_pkg::REQ_CHUNK, 17'sd0, 1'b1));
      // single byte payload
      send(make_req(arir_pkg::REQ_ECHO_HDR, 17'sd1, 1'b0));
      send(it);
   endtask

   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= arir_pkg::REQ_ARP;
      req_bus.frame_src_mac <= '0;
      req_bus.sender_mac    <= '0;
      req_bus.sender_ip     <= '0;
      req_bus.target_ip     <= '0;
      req_bus.ip_ident      <= '0;
      req_bus.echo_ident    <= '0;
      req_bus.echo_seq      <= '0;
      req_bus.data_len      <= '0;
      req_bus.chunk_data    <= '0;
      req_bus.chunk_last    <= 1'b0;
      tx_idle_pct = 37;
      rx_idle_pct = 46;
      used_count  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mac(48'hFFFF_FFFF_FFFF);
      directed();
      settle(DRAIN_CYCLES);

      // first random phase, with a long receiver hold in the middle
      write_mac(48'({$urandom, $urandom}));
      random_phase(40);
      -> hold_rx;
      run_echo(17'sd300, 0);
      run_echo(17'(MAX_PAYLOAD), 0);
      random_phase(80);
      settle(DRAIN_CYCLES);

      // swapped idle rates
      tx_idle_pct = 46;
      rx_idle_pct = 37;
      write_mac(48'h0);
      random_phase(110);
      settle(DRAIN_CYCLES);

      // back to back
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_mac(48'({$urandom, $urandom}));
      random_phase(110);
      settle(DRAIN_CYCLES);

      if (sb.errors == 0) begin
         $display("PASS arp_icmp_reply_builder");
      end else begin
         $display("FAIL arp_icmp_reply_builder");
      end
      $finish;
   end

endmodule

// File: sim.f
src/arir_pkg.sv
src/arir_if.sv
src/arp_icmp_reply_builder.sv
tb/tb_arp_icmp_reply_builder.sv
